/* hw/rtl/dcfp_pkg.sv */
// ----------------------------------------------------------------------------
// dcfp_pkg: shared definitions for the delimited command frame parser
// sizes, register codes, command strings, controller state and the
// command/status structs that join controller and datapath
// ----------------------------------------------------------------------------
package dcfp_pkg;

   localparam int FRAME_BYTES = 50;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int BYTE_W      = 8;
   localparam int LAMP_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_START_CHAR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CHAR   = 1'd1;

   localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'h23;
   localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'h2a;

   localparam logic [LAMP_W-1:0] LAMP_ON    = 2'd0;
   localparam logic [LAMP_W-1:0] LAMP_OFF   = 2'd1;
   localparam logic [LAMP_W-1:0] LAMP_UNSET = 2'd2;

   localparam int ON_LEN  = 9;
   localparam int OFF_LEN = 10;
   localparam int WIN_LEN = 10;

   // lamp on command text
   localparam logic [BYTE_W-1:0] CMD_ON [ON_LEN] = '{
      8'h64, 8'h65, 8'h6e, 8'h67, 8'h5f, 8'h6f, 8'h70, 8'h65, 8'h6e
   };
   // lamp off command text
   localparam logic [BYTE_W-1:0] CMD_OFF [OFF_LEN] = '{
      8'h64, 8'h65, 8'h6e, 8'h67, 8'h5f, 8'h63, 8'h6c, 8'h6f, 8'h73, 8'h65
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;      // input transaction accepted this cycle
      logic scan_en;   // walk the store for length and commands
      logic finish;    // scan complete: update lamp, set up echo
      logic emit_en;   // walk the store and echo bytes
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_end; // current input byte closes a frame
      logic scan_done;
      logic emit_last; // final result loads this cycle
   } dp_sts_type;

endpackage

/* hw/rtl/dcfp_if.sv */
// ----------------------------------------------------------------------------
// dcfp_if: valid/ready channels of the frame parser
// request carries one received byte, response carries one echo result
// ----------------------------------------------------------------------------
interface dcfp_req_if;
   logic                          valid;
   logic                          ready;
   logic [dcfp_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcfp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dcfp_pkg::BYTE_W-1:0]   echo_byte;
   logic                          byte_valid;
   logic                          last;
   logic [dcfp_pkg::LAMP_W-1:0]   lamp_command;

   modport source (output valid, output echo_byte, output byte_valid, output last,
                   output lamp_command, input ready);
   modport sink   (input valid, input echo_byte, input byte_valid, input last,
                   input lamp_command, output ready);
endinterface

/* hw/rtl/delimited_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// delimited_command_frame_parser: framed command receiver
// frames received bytes between start and end characters, echoes the
// payload at frame end and tracks the lamp command found in it
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    rx_byte
//   rsp_bus   out        valid/ready    echo_byte, byte_valid, last, lamp_command
//   csr_*     in         write enable   csr_index, csr_wdata
//
// a byte that does not close a frame is taken in idle and keeps the input open
// a closing byte starts a store scan (one store read port, one byte a cycle)
// and then the echo of the payload, the input stays blocked through both
// the next byte is taken while the final result still waits in the output reg
// a stalled response holds the echo phase, request ready stays low meanwhile
// reset is synchronous; the store needs no clearing pass, the byte count
// marks which entries are live
//
module delimited_command_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   dcfp_req_if.sink                         req_bus,
   dcfp_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [dcfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // controller to datapath commands and status back
   dcfp_pkg::ctl_cmd_type cmd;
   dcfp_pkg::dp_sts_type  sts;
   logic                  ctl_ready;

   // sequencer: idle accepts bytes, scan and echo phases block input
   dcfp_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_bus.ready = ctl_ready;

   // byte count, payload store, search window and output register
   dcfp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_bus.rx_byte),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp_bus)
   );

endmodule

/* hw/rtl/dcfp_ctl.sv */
// ----------------------------------------------------------------------------
// dcfp_ctl: frame parser controller
// sequences idle, store scan and echo phases
// ----------------------------------------------------------------------------
module dcfp_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dcfp_pkg::dp_sts_type  sts,
   output dcfp_pkg::ctl_cmd_type cmd
);

   dcfp_pkg::state_type state_ff;
   dcfp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         dcfp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && sts.frame_end) begin
               state_in = dcfp_pkg::ST_SCAN;
            end
         end
         dcfp_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               cmd.finish = 1'b1;
               state_in   = dcfp_pkg::ST_EMIT;
            end
         end
         dcfp_pkg::ST_EMIT: begin
            cmd.emit_en = 1'b1;
            if (sts.emit_last) begin
               state_in = dcfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcfp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/dcfp_datapath.sv */
// ----------------------------------------------------------------------------
// dcfp_datapath: frame parser datapath
// config registers, byte count, payload memory, command search window
// and the result output register
// ----------------------------------------------------------------------------
module dcfp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [dcfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dcfp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [dcfp_pkg::BYTE_W-1:0]       rx_byte,
   input  dcfp_pkg::ctl_cmd_type             cmd,
   output dcfp_pkg::dp_sts_type              sts,
   dcfp_rsp_if.source                        rsp
);

   localparam int IW = dcfp_pkg::IDX_W;
   localparam int CW = dcfp_pkg::CNT_W;
   localparam int BW = dcfp_pkg::BYTE_W;
   localparam int LW = dcfp_pkg::LAMP_W;
   localparam int WL = dcfp_pkg::WIN_LEN;

   logic [BW-1:0] start_ff, start_in, end_ff, end_in;
   logic [CW-1:0] count_ff, count_in;
   logic          armed_ff, armed_in;
   logic [LW-1:0] lamp_ff, lamp_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] eidx_ff, eidx_in;
   logic          rv_ff, rv_in;
   logic          stop_ff, stop_in;
   logic          on_ff, on_in, off_ff, off_in;
   logic [BW-1:0] win_ff [WL];
   logic [BW-1:0] win_in [WL];
   logic [BW-1:0] win_shift [WL];

   logic          out_valid_ff, out_valid_in;
   logic [BW-1:0] echo_ff, echo_in;
   logic          bval_ff, bval_in;
   logic          last_ff, last_in;
   logic [LW-1:0] olamp_ff, olamp_in;

   logic [BW-1:0] mem [dcfp_pkg::FRAME_BYTES];
   logic [BW-1:0] rd_data_ff;

   logic          over, is_start, is_end, pass;
   logic          store_wr;
   logic [CW-1:0] cnt_m1;
   logic          match_on, match_off;
   logic          scan_issue, emit_issue, rd_issue;
   logic          out_free, empty, load_empty, load_byte;

   // frame step decode
   always_comb begin
      over     = (count_ff >= CW'(dcfp_pkg::FRAME_BYTES));
      is_start = (rx_byte == start_ff);
      is_end   = (rx_byte == end_ff);
      pass     = !over && (armed_ff || is_start);
      cnt_m1   = count_ff - CW'(1);
      store_wr = cmd.take && pass && !is_end && (count_ff != '0);
   end

   // command search on the window including the byte now being scanned
   always_comb begin
      win_shift[0] = rd_data_ff;
      for (int j = 1; j < WL; j++) begin
         win_shift[j] = win_ff[j-1];
      end
      match_on = 1'b1;
      for (int j = 0; j < dcfp_pkg::ON_LEN; j++) begin
         if (win_shift[j] != dcfp_pkg::CMD_ON[dcfp_pkg::ON_LEN-1-j]) begin
            match_on = 1'b0;
         end
      end
      match_off = 1'b1;
      for (int j = 0; j < dcfp_pkg::OFF_LEN; j++) begin
         if (win_shift[j] != dcfp_pkg::CMD_OFF[dcfp_pkg::OFF_LEN-1-j]) begin
            match_off = 1'b0;
         end
      end
   end

   always_comb begin
      out_free   = !out_valid_ff || rsp.ready;
      empty      = (len_ff == '0);
      load_empty = cmd.emit_en && empty && out_free;
      load_byte  = cmd.emit_en && !empty && rv_ff && out_free;
      scan_issue = cmd.scan_en && (ptr_ff < fill_ff);
      emit_issue = cmd.emit_en && !empty && (ptr_ff < len_ff) && (!rv_ff || load_byte);
      rd_issue   = scan_issue || emit_issue;

      sts.frame_end = pass && is_end;
      sts.scan_done = (ptr_ff == fill_ff) && !rv_ff;
      sts.emit_last = load_empty || (load_byte && (eidx_ff == len_ff - IW'(1)));
   end

   always_comb begin
      start_in     = start_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      lamp_in      = lamp_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      eidx_in      = eidx_ff;
      rv_in        = rv_ff;
      stop_in      = stop_ff;
      on_in        = on_ff;
      off_in       = off_ff;
      win_in       = win_ff;
      out_valid_in = out_valid_ff;
      echo_in      = echo_ff;
      bval_in      = bval_ff;
      last_in      = last_ff;
      olamp_in     = olamp_ff;

      if (csr_we) begin
         case (csr_index)
            dcfp_pkg::CSR_START_CHAR: start_in = csr_wdata[BW-1:0];
            dcfp_pkg::CSR_END_CHAR:   end_in   = csr_wdata[BW-1:0];
            default: ;
         endcase
      end

      // one received byte
      if (cmd.take) begin
         if (over) begin
            count_in = '0;
         end else if (pass) begin
            if (count_ff == '0) begin
               armed_in = is_start;
            end
            if (is_end) begin
               fill_in  = (count_ff == '0) ? '0 : cnt_m1[IW-1:0];
               count_in = '0;
               armed_in = 1'b0;
               ptr_in   = '0;
               rv_in    = 1'b0;
               stop_in  = 1'b0;
               len_in   = '0;
               on_in    = 1'b0;
               off_in   = 1'b0;
               for (int j = 0; j < WL; j++) begin
                  win_in[j] = '0;
               end
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
      end

      // scan: length up to first zero, command search
      if (cmd.scan_en) begin
         rv_in = scan_issue;
         if (scan_issue) begin
            ptr_in = ptr_ff + IW'(1);
         end
         if (rv_ff && !stop_ff) begin
            if (rd_data_ff == '0) begin
               stop_in = 1'b1;
            end else begin
               win_in = win_shift;
               len_in = len_ff + IW'(1);
               on_in  = on_ff || match_on;
               off_in = off_ff || match_off;
            end
         end
      end

      if (cmd.finish) begin
         if (on_ff) begin
            lamp_in = dcfp_pkg::LAMP_ON;
         end else if (off_ff) begin
            lamp_in = dcfp_pkg::LAMP_OFF;
         end
         ptr_in  = '0;
         rv_in   = 1'b0;
         eidx_in = '0;
      end

      // echo: prefetched byte waits in rd_data_ff for the output register
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_empty) begin
         out_valid_in = 1'b1;
         echo_in      = '0;
         bval_in      = 1'b0;
         last_in      = 1'b1;
         olamp_in     = lamp_ff;
      end
      if (load_byte) begin
         out_valid_in = 1'b1;
         echo_in      = rd_data_ff;
         bval_in      = 1'b1;
         last_in      = (eidx_ff == len_ff - IW'(1));
         olamp_in     = lamp_ff;
         eidx_in      = eidx_ff + IW'(1);
      end
      if (cmd.emit_en) begin
         if (emit_issue) begin
            rv_in  = 1'b1;
            ptr_in = ptr_ff + IW'(1);
         end else if (load_byte) begin
            rv_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= dcfp_pkg::START_CHAR_RESET;
         end_ff       <= dcfp_pkg::END_CHAR_RESET;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         lamp_ff      <= dcfp_pkg::LAMP_UNSET;
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         lamp_ff      <= lamp_in;
         rv_ff        <= rv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff  <= fill_in;
      ptr_ff   <= ptr_in;
      len_ff   <= len_in;
      eidx_ff  <= eidx_in;
      stop_ff  <= stop_in;
      on_ff    <= on_in;
      off_ff   <= off_in;
      win_ff   <= win_in;
      echo_ff  <= echo_in;
      bval_ff  <= bval_in;
      last_ff  <= last_in;
      olamp_ff <= olamp_in;
   end

   // payload store, entries past the fill count are never read
   always_ff @(posedge clock) begin
      if (store_wr) begin
         mem[cnt_m1[IW-1:0]] <= rx_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.echo_byte    = echo_ff;
   assign rsp.byte_valid   = bval_ff;
   assign rsp.last         = last_ff;
   assign rsp.lamp_command = olamp_ff;

endmodule

/* hw/rtl/dcfp_checker.sv */
// ----------------------------------------------------------------------------
// dcfp_checker: port level checks for the frame parser
// watches the response channel and its tie to request ready
// ----------------------------------------------------------------------------
module dcfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dcfp_pkg::BYTE_W-1:0]   rsp_echo_byte,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last,
   input logic [dcfp_pkg::LAMP_W-1:0]   rsp_lamp_command
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_last) && $stable(rsp_lamp_command))
      else $error("stalled response changed");

   // an empty payload result is the only result of its frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && (rsp_echo_byte == '0))
      else $error("empty result malformed");

   // no new byte taken while an echo is still running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted during echo");

   // lamp code stays in its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lamp_command == dcfp_pkg::LAMP_ON)
         || (rsp_lamp_command == dcfp_pkg::LAMP_OFF)
         || (rsp_lamp_command == dcfp_pkg::LAMP_UNSET))
      else $error("bad lamp code");

endmodule

bind delimited_command_frame_parser dcfp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_echo_byte    (rsp_bus.echo_byte),
   .rsp_byte_valid   (rsp_bus.byte_valid),
   .rsp_last         (rsp_bus.last),
   .rsp_lamp_command (rsp_bus.lamp_command)
);
